FILE: sv/tefr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tefr_pkg
// Shared constants and types of the edge-function triangle rasterizer.
// ----------------------------------------------------------------------------
package tefr_pkg;

    localparam int FH_W = 13;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;
    localparam int PY_W = 14;
    localparam int RED_W = 8;
    localparam logic [RED_W-1:0] RED_SAT = 8'd255;

    // input item modes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // command kinds in the queue
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_flags;

endpackage

FILE: sv/tefr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tefr_queue
// Two-entry command queue between the scan front and the shading back.
// ----------------------------------------------------------------------------
module tefr_queue import tefr_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_fifo_flags  o_flags
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_push, w_pop;

    assign w_push = i_push && (r_cnt != 2'd2);
    assign w_pop  = i_pop && (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];
    assign o_flags.full  = (r_cnt == 2'd2);
    assign o_flags.empty = (r_cnt == 2'd0);

    // store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            if (w_push && !w_pop) r_cnt <= r_cnt + 2'd1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

FILE: sv/tefr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tefr_front
// Accepts items, forms the bounding box and walks the scan, queueing commands.
// ----------------------------------------------------------------------------
module tefr_front import tefr_pkg::*; #(
    parameter int FRAC = 4,
    parameter int INT  = 12,
    parameter int CW   = FRAC + INT,
    parameter int CMDW = 2 + 2 * INT + PY_W + 6 * CW + 3 * RED_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_mode,
    input  logic signed [CW-1:0]   i_vert0_x,
    input  logic signed [CW-1:0]   i_vert0_y,
    input  logic signed [CW-1:0]   i_vert1_x,
    input  logic signed [CW-1:0]   i_vert1_y,
    input  logic signed [CW-1:0]   i_vert2_x,
    input  logic signed [CW-1:0]   i_vert2_y,
    input  logic [RED_W-1:0]       i_red0,
    input  logic [RED_W-1:0]       i_red1,
    input  logic [RED_W-1:0]       i_red2,
    input  logic [FH_W-1:0]        i_frame_height,
    input  t_fifo_flags            i_flags,
    output logic                   o_push,
    output logic [CMDW-1:0]        o_cmd
);

    localparam logic [CW-1:0] FMASK = CW'((1 << FRAC) - 1);

    logic signed [INT-1:0] r_bx_min, r_bx_max, r_by_min, r_by_max;
    logic signed [INT-1:0] r_sx, r_sy;
    logic                  r_active;
    logic signed [INT-1:0] n_sx, n_sy;
    logic                  n_active, w_last, w_accept;
    logic signed [INT-1:0] w_bx_min, w_bx_max, w_by_min, w_by_max;
    logic [PY_W-1:0]       w_fy;

    function automatic logic signed [INT-1:0] f_to_pixel(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] q;
        q = v >>> FRAC;
        if (v[CW-1] && ((v & FMASK) != '0)) q = q + CW'(1);
        return INT'(q);
    endfunction

    function automatic logic signed [CW-1:0] f_min3(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b,
                                                    input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CW-1:0] f_max3(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b,
                                                    input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    assign o_in_stall = i_flags.full;
    assign w_accept   = i_in_valid && !i_flags.full;

    // bounding box of the incoming triangle
    assign w_bx_min = f_to_pixel(f_min3(i_vert0_x, i_vert1_x, i_vert2_x));
    assign w_bx_max = f_to_pixel(f_max3(i_vert0_x, i_vert1_x, i_vert2_x));
    assign w_by_min = f_to_pixel(f_min3(i_vert0_y, i_vert1_y, i_vert2_y));
    assign w_by_max = f_to_pixel(f_max3(i_vert0_y, i_vert1_y, i_vert2_y));

    assign w_fy = PY_W'(i_frame_height) - PY_W'(r_sy);

    // next scan position
    always_comb begin
        n_sx = r_sx;
        n_sy = r_sy;
        n_active = r_active;
        w_last = 1'b0;
        if (r_sy < r_by_max) begin
            n_sy = r_sy + INT'(1);
        end else if (r_sx < r_bx_max) begin
            n_sy = r_by_min;
            n_sx = r_sx + INT'(1);
        end else begin
            w_last = 1'b1;
            n_active = 1'b0;
        end
    end

    // build the command for the queue
    always_comb begin
        o_push = 1'b0;
        o_cmd  = {CMD_PIXEL, w_last, r_sx, r_sy, w_fy,
                  i_vert0_x, i_vert0_y, i_vert1_x, i_vert1_y, i_vert2_x, i_vert2_y,
                  i_red0, i_red1, i_red2};
        if (w_accept) begin
            if (i_mode == MODE_LOAD) begin
                o_push = 1'b1;
                o_cmd[CMDW-1] = CMD_LOAD;
            end else begin
                o_push = r_active;
            end
        end
    end

    // hold box and scan position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_bx_min <= '0;
            r_bx_max <= '0;
            r_by_min <= '0;
            r_by_max <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
        end else if (w_accept) begin
            if (i_mode == MODE_LOAD) begin
                r_bx_min <= w_bx_min;
                r_bx_max <= w_bx_max;
                r_by_min <= w_by_min;
                r_by_max <= w_by_max;
                r_sx     <= w_bx_min;
                r_sy     <= w_by_min;
                r_active <= 1'b1;
            end else if (r_active) begin
                r_sx     <= n_sx;
                r_sy     <= n_sy;
                r_active <= n_active;
            end
        end
    end

endmodule

FILE: sv/tefr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tefr_back
// Evaluates edge functions with one shared multiplier and divides for red.
// ----------------------------------------------------------------------------
module tefr_back import tefr_pkg::*; #(
    parameter int FRAC = 4,
    parameter int INT  = 12,
    parameter int CW   = FRAC + INT,
    parameter int CMDW = 2 + 2 * INT + PY_W + 6 * CW + 3 * RED_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_fifo_flags            i_flags,
    input  logic [CMDW-1:0]        i_cmd,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [INT-1:0]  o_pixel_x,
    output logic signed [PY_W-1:0] o_pixel_y,
    output logic                   o_covered,
    output logic [RED_W-1:0]       o_red_out,
    output logic                   o_divide_fault,
    output logic                   o_last
);

    localparam int DW = CW + 1;
    localparam int EW = 2 * CW + 3;
    localparam int AW = 2 * CW + 4;
    localparam int PW = 2 * CW + 12;
    localparam int NW = 2 * CW + 13;
    localparam int RED_OFS = 0;
    localparam int CRD_OFS = 3 * RED_W;
    localparam int FY_OFS  = CRD_OFS + 6 * CW;
    localparam int Y_OFS   = FY_OFS + PY_W;
    localparam int X_OFS   = Y_OFS + INT;
    localparam int LAST_BIT = X_OFS + INT;
    localparam int KIND_BIT = LAST_BIT + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]            r_state;
    logic [3:0]            r_k;
    logic                  r_load;
    logic signed [CW-1:0]  r_vx [3];
    logic signed [CW-1:0]  r_vy [3];
    logic [RED_W-1:0]      r_red [3];
    logic signed [CW-1:0]  r_px, r_py;
    logic signed [AW-1:0]  r_area;
    logic signed [AW-1:0]  r_acc;
    logic signed [EW-1:0]  r_e [3];
    logic signed [PW-1:0]  r_prod;
    logic signed [NW-1:0]  r_num;
    logic [NW-1:0]         r_rem, r_dv;
    logic [RED_W-1:0]      r_q;
    logic                  r_cov, r_fault;
    logic signed [INT-1:0] r_x;
    logic [PY_W-1:0]       r_fy;
    logic                  r_lst;
    logic                  r_ov;
    logic signed [INT-1:0] r_ox;
    logic [PY_W-1:0]       r_oy;
    logic                  r_ocov, r_ofault, r_olast;
    logic [RED_W-1:0]      r_ored;

    logic signed [EW-1:0]    w_a;
    logic signed [DW-1:0]    w_b;
    logic signed [EW+DW-1:0] w_full;
    logic signed [EW-1:0]    w_esum;
    logic                    w_cov, w_fault, w_ge;
    logic [NW-1:0]           w_area_u;
    logic signed [INT-1:0]   w_cx, w_cy;

    assign o_pop = (r_state == S_IDLE) && !i_flags.empty;
    assign w_cx  = i_cmd[X_OFS +: INT];
    assign w_cy  = i_cmd[Y_OFS +: INT];

    // select multiplier operands for the current step
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_k)
            4'd0: begin w_a = EW'(DW'(r_vy[1]) - DW'(r_vy[0])); w_b = DW'(r_px) - DW'(r_vx[0]); end
            4'd1: begin w_a = EW'(DW'(r_vx[1]) - DW'(r_vx[0])); w_b = DW'(r_py) - DW'(r_vy[0]); end
            4'd2: begin w_a = EW'(DW'(r_vy[2]) - DW'(r_vy[1])); w_b = DW'(r_px) - DW'(r_vx[1]); end
            4'd3: begin w_a = EW'(DW'(r_vx[2]) - DW'(r_vx[1])); w_b = DW'(r_py) - DW'(r_vy[1]); end
            4'd4: begin w_a = EW'(DW'(r_vy[0]) - DW'(r_vy[2])); w_b = DW'(r_px) - DW'(r_vx[2]); end
            4'd5: begin w_a = EW'(DW'(r_vx[0]) - DW'(r_vx[2])); w_b = DW'(r_py) - DW'(r_vy[2]); end
            4'd6: begin w_a = r_e[1]; w_b = DW'(signed'({1'b0, r_red[0]})); end
            4'd7: begin w_a = r_e[2]; w_b = DW'(signed'({1'b0, r_red[1]})); end
            4'd8: begin w_a = r_e[0]; w_b = DW'(signed'({1'b0, r_red[2]})); end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_full   = w_a * w_b;
    assign w_esum   = EW'(r_acc) + EW'(r_prod);
    assign w_cov    = !r_e[0][EW-1] && !r_e[1][EW-1] && !r_e[2][EW-1];
    assign w_fault  = w_cov && (r_area[AW-1] || (r_area == '0));
    assign w_area_u = NW'(unsigned'(r_area));
    assign w_ge     = (r_rem >= r_dv);

    // sequence one command through multiply, check and divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_flags.empty) begin
                        r_state <= S_MUL;
                        if (i_cmd[KIND_BIT] == CMD_LOAD) begin
                            r_load <= 1'b1;
                            r_k    <= 4'd2;
                            r_vx[0] <= i_cmd[CRD_OFS + 5 * CW +: CW];
                            r_vy[0] <= i_cmd[CRD_OFS + 4 * CW +: CW];
                            r_vx[1] <= i_cmd[CRD_OFS + 3 * CW +: CW];
                            r_vy[1] <= i_cmd[CRD_OFS + 2 * CW +: CW];
                            r_vx[2] <= i_cmd[CRD_OFS + CW +: CW];
                            r_vy[2] <= i_cmd[CRD_OFS +: CW];
                            r_px    <= i_cmd[CRD_OFS + 5 * CW +: CW];
                            r_py    <= i_cmd[CRD_OFS + 4 * CW +: CW];
                            r_red[0] <= i_cmd[RED_OFS + 2 * RED_W +: RED_W];
                            r_red[1] <= i_cmd[RED_OFS + RED_W +: RED_W];
                            r_red[2] <= i_cmd[RED_OFS +: RED_W];
                        end else begin
                            r_load <= 1'b0;
                            r_k    <= 4'd0;
                            r_px   <= CW'(w_cx) <<< FRAC;
                            r_py   <= CW'(w_cy) <<< FRAC;
                            r_x    <= w_cx;
                            r_fy   <= i_cmd[FY_OFS +: PY_W];
                            r_lst  <= i_cmd[LAST_BIT];
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= PW'(w_full);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    // even steps start an edge, odd steps finish it
                    if (r_k < 4'd6) begin
                        if (!r_k[0]) begin
                            r_acc <= -AW'(r_prod);
                        end else if (r_load) begin
                            r_area <= r_acc + AW'(r_prod);
                        end else begin
                            unique case (r_k[2:1])
                                2'd0: r_e[0] <= w_esum;
                                2'd1: r_e[1] <= w_esum;
                                default: r_e[2] <= w_esum;
                            endcase
                        end
                    end else if (r_k == 4'd6) begin
                        r_num <= NW'(r_prod);
                    end else begin
                        r_num <= r_num + NW'(r_prod);
                    end
                    if (r_load && r_k == 4'd3) begin
                        r_state <= S_IDLE;
                    end else if (r_k == 4'd8) begin
                        r_state <= S_CHK;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_CHK: begin
                    r_cov   <= w_cov;
                    r_fault <= w_fault;
                    r_rem   <= unsigned'(r_num);
                    r_dv    <= w_area_u << (RED_W - 1);
                    r_k     <= 4'd7;
                    if (!w_cov || w_fault) begin
                        r_q     <= '0;
                        r_state <= S_OUT;
                    end else if (unsigned'(r_num) >= (w_area_u << RED_W)) begin
                        r_q     <= RED_SAT;
                        r_state <= S_OUT;
                    end else begin
                        r_q     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle, high bit first
                    if (w_ge) r_rem <= r_rem - r_dv;
                    r_dv <= r_dv >> 1;
                    r_q  <= {r_q[RED_W-2:0], w_ge};
                    r_k  <= r_k - 4'd1;
                    if (r_k == 4'd0) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ov || !i_out_stall)) begin
            r_ox     <= r_x;
            r_oy     <= r_fy;
            r_ocov   <= r_cov;
            r_ored   <= r_q;
            r_ofault <= r_fault;
            r_olast  <= r_lst;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_pixel_x      = r_ox;
    assign o_pixel_y      = signed'(r_oy);
    assign o_covered      = r_ocov;
    assign o_red_out      = r_ored;
    assign o_divide_fault = r_ofault;
    assign o_last         = r_olast;

endmodule

FILE: sv/triangle_edge_function_rasterizer_core.sv
`timescale 1ns / 1ps
// A load holds the shading unit while it computes the triangle area; a pixel passes from
// transfer to result through 9 multiplies on one shared multiplier, a check, the
// bit-serial divide when needed and the output register.
// The shading unit pops a new command only from idle, once it is through with the last;
// a 2-entry queue decouples input from shading.
// Reset (synchronous, active low) clears scan, queue and output valid; frame height 480.
// ----------------------------------------------------------------------------
// triangle_edge_function_rasterizer_core
// Half-space triangle rasterizer with barycentric red interpolation.
// ----------------------------------------------------------------------------
module triangle_edge_function_rasterizer_core import tefr_pkg::*; #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int COORD_INT_BITS  = 12
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_cfg_we,
    input  logic [FH_W-1:0]                                   i_cfg_data,
    input  logic                                              i_in_valid,
    output logic                                              o_in_stall,
    input  logic                                              i_mode,
    input  logic signed [COORD_FRAC_BITS+COORD_INT_BITS-1:0]  i_vert0_x,
    input  logic signed [COORD_FRAC_BITS+COORD_INT_BITS-1:0]  i_vert0_y,
    input  logic signed [COORD_FRAC_BITS+COORD_INT_BITS-1:0]  i_vert1_x,
    input  logic signed [COORD_FRAC_BITS+COORD_INT_BITS-1:0]  i_vert1_y,
    input  logic signed [COORD_FRAC_BITS+COORD_INT_BITS-1:0]  i_vert2_x,
    input  logic signed [COORD_FRAC_BITS+COORD_INT_BITS-1:0]  i_vert2_y,
    input  logic [RED_W-1:0]                                  i_red0,
    input  logic [RED_W-1:0]                                  i_red1,
    input  logic [RED_W-1:0]                                  i_red2,
    output logic                                              o_out_valid,
    input  logic                                              i_out_stall,
    output logic signed [COORD_INT_BITS-1:0]                  o_pixel_x,
    output logic signed [PY_W-1:0]                            o_pixel_y,
    output logic                                              o_covered,
    output logic [RED_W-1:0]                                  o_red_out,
    output logic                                              o_divide_fault,
    output logic                                              o_last
);

    localparam int CW   = COORD_FRAC_BITS + COORD_INT_BITS;
    localparam int CMDW = 2 + 2 * COORD_INT_BITS + PY_W + 6 * CW + 3 * RED_W;

    logic [FH_W-1:0] r_frame_height;
    logic            w_push, w_pop;
    logic [CMDW-1:0] w_cmd_in, w_cmd_out;
    t_fifo_flags     w_flags;

    // frame height register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_height <= FH_RESET;
        end else if (i_cfg_we) begin
            r_frame_height <= i_cfg_data;
        end
    end

    tefr_front #(.FRAC(COORD_FRAC_BITS), .INT(COORD_INT_BITS)) u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_mode,
        .i_vert0_x, .i_vert0_y, .i_vert1_x, .i_vert1_y, .i_vert2_x, .i_vert2_y,
        .i_red0, .i_red1, .i_red2,
        .i_frame_height(r_frame_height),
        .i_flags(w_flags),
        .o_push(w_push),
        .o_cmd(w_cmd_in)
    );

    tefr_queue #(.W(CMDW)) u_queue (
        .i_clk, .i_rst_n,
        .i_push(w_push), .i_data(w_cmd_in),
        .i_pop(w_pop), .o_data(w_cmd_out),
        .o_flags(w_flags)
    );

    tefr_back #(.FRAC(COORD_FRAC_BITS), .INT(COORD_INT_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_flags(w_flags), .i_cmd(w_cmd_out), .o_pop(w_pop),
        .o_out_valid, .i_out_stall,
        .o_pixel_x, .o_pixel_y, .o_covered, .o_red_out, .o_divide_fault, .o_last
    );

endmodule

FILE: sv/tefr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tefr_checker
// Port-level checks of the rasterizer result stream.
// ----------------------------------------------------------------------------
module tefr_checker import tefr_pkg::*; #(
    parameter int COORD_INT_BITS = 12
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [COORD_INT_BITS-1:0] o_pixel_x,
    input logic                      o_covered,
    input logic [RED_W-1:0]          o_red_out,
    input logic                      o_divide_fault
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result stays valid and holds its x
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x))
        else $error("stalled result changed");

    // a fault only on a covered pixel
    a_fault_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_fault |-> o_covered)
        else $error("divide fault on uncovered pixel");

    // red only where covered and not faulted
    a_red_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (!o_covered || o_divide_fault) |-> o_red_out == '0)
        else $error("red on uncovered or faulted pixel");

endmodule

bind triangle_edge_function_rasterizer_core tefr_checker #(
    .COORD_INT_BITS(COORD_INT_BITS)
) u_tefr_checker (
    .i_clk, .i_rst_n, .o_out_valid, .i_out_stall,
    .o_pixel_x, .o_covered, .o_red_out, .o_divide_fault
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edge-function triangle rasterizer. Loads
// triangles, scans their bounding boxes and compares every pixel against a
// built-in scan and shading predictor, with random gaps and stalls on both
// sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import tefr_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic         mode;
        shortint      v[6];
        byte unsigned r[3];
    } tri_item_t;

    typedef struct {
        logic [11:0]      x;
        logic [PY_W-1:0]  y;
        logic             cov;
        logic [RED_W-1:0] red;
        logic             fault;
        logic             last;
    } pixel_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [FH_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic signed [15:0] vx0 = '0, vy0 = '0, vx1 = '0, vy1 = '0, vx2 = '0, vy2 = '0;
    logic [7:0] r0 = '0, r1 = '0, r2 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [11:0] pix_x;
    logic signed [PY_W-1:0] pix_y;
    logic covered, divide_fault, last_pix;
    logic [RED_W-1:0] red_out;

    // bench state
    bit noisy = 1'b1;
    bit hold_out = 1'b0;
    int mismatches = 0;
    int cycles = 0;
    pixel_t expected_pixels[$];

    // predictor state
    longint tri_v[6];
    longint tri_r[3];
    longint box[4];
    longint cur_x, cur_y, area;
    bit scanning;
    logic [FH_W-1:0] height = FH_RESET;

    triangle_edge_function_rasterizer_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode),
        .i_vert0_x(vx0), .i_vert0_y(vy0), .i_vert1_x(vx1), .i_vert1_y(vy1),
        .i_vert2_x(vx2), .i_vert2_y(vy2),
        .i_red0(r0), .i_red1(r1), .i_red2(r2),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_pixel_x(pix_x), .o_pixel_y(pix_y), .o_covered(covered),
        .o_red_out(red_out), .o_divide_fault(divide_fault), .o_last(last_pix)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        out_stall = hold_out || (noisy && $urandom_range(0, 99) < 22);
    end

    function automatic longint edge_val(int a, int b, longint px, longint py);
        longint ax, ay, bx, by;
        ax = tri_v[2*a];
        ay = tri_v[2*a+1];
        bx = tri_v[2*b];
        by = tri_v[2*b+1];
        return -((by - ay) * (px - ax)) + (bx - ax) * (py - ay);
    endfunction

    // truncate toward zero, wrap to 12 signed bits
    function automatic longint to_pix(longint v);
        logic signed [11:0] w;
        w = 12'(v / 16);
        return longint'(w);
    endfunction

    // advance the predicted scan for one accepted transfer
    task automatic predict(tri_item_t it);
        longint e01, e12, e20, num, q, px, py;
        pixel_t p;
        if (it.mode == MODE_LOAD) begin
            for (int i = 0; i < 6; i++) tri_v[i] = it.v[i];
            for (int i = 0; i < 3; i++) tri_r[i] = it.r[i];
            for (int k = 0; k < 2; k++) begin
                box[2*k]   = to_pix(tri_v[k] < tri_v[k+2] ?
                    (tri_v[k] < tri_v[k+4] ? tri_v[k] : tri_v[k+4]) :
                    (tri_v[k+2] < tri_v[k+4] ? tri_v[k+2] : tri_v[k+4]));
                box[2*k+1] = to_pix(tri_v[k] > tri_v[k+2] ?
                    (tri_v[k] > tri_v[k+4] ? tri_v[k] : tri_v[k+4]) :
                    (tri_v[k+2] > tri_v[k+4] ? tri_v[k+2] : tri_v[k+4]));
            end
            area = edge_val(1, 2, tri_v[0], tri_v[1]);
            cur_x = box[0];
            cur_y = box[2];
            scanning = 1'b1;
            return;
        end
        if (!scanning) return;
        px = cur_x * 16;
        py = cur_y * 16;
        e01 = edge_val(0, 1, px, py);
        e12 = edge_val(1, 2, px, py);
        e20 = edge_val(2, 0, px, py);
        p.cov = (e01 >= 0 && e12 >= 0 && e20 >= 0);
        p.fault = 1'b0;
        p.red = '0;
        if (p.cov) begin
            if (area <= 0) begin
                p.fault = 1'b1;
            end else begin
                num = e12 * tri_r[0] + e20 * tri_r[1] + e01 * tri_r[2];
                q = num / area;
                p.red = (q > 255) ? RED_SAT : 8'(q);
            end
        end
        p.x = 12'(cur_x);
        p.y = PY_W'(longint'(height) - cur_y);
        p.last = 1'b0;
        if (cur_y < box[3]) begin
            cur_y++;
        end else if (cur_x < box[1]) begin
            cur_y = box[2];
            cur_x++;
        end else begin
            p.last = 1'b1;
            scanning = 1'b0;
        end
        expected_pixels.push_back(p);
    endtask

    // compare each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        pixel_t e;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel x=%0d y=%0d", pix_x, pix_y);
            end else begin
                e = expected_pixels.pop_front();
                if (pix_x !== e.x || pix_y !== e.y || covered !== e.cov ||
                    red_out !== e.red || divide_fault !== e.fault || last_pix !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel mismatch: exp x=%0d y=%0d c=%b r=%0d f=%b l=%b,",
                                  " got x=%0d y=%0d c=%b r=%0d f=%b l=%b"},
                            $signed(e.x), $signed(e.y), e.cov, e.red, e.fault, e.last,
                            pix_x, pix_y, covered, red_out, divide_fault, last_pix);
                end
            end
        end
    end

    // drive one transfer, called and returning at a falling edge
    task automatic send_item(tri_item_t it);
        while (noisy && $urandom_range(0, 99) < 22) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        mode = it.mode;
        {vx0, vy0, vx1, vy1, vx2, vy2} = {it.v[0], it.v[1], it.v[2], it.v[3], it.v[4], it.v[5]};
        {r0, r1, r2} = {it.r[0], it.r[1], it.r[2]};
        do @(posedge i_clk); while (in_stall);
        predict(it);
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    task automatic load_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                            int c0, int c1, int c2);
        tri_item_t it;
        it.mode = MODE_LOAD;
        it.v = '{shortint'(x0), shortint'(y0), shortint'(x1), shortint'(y1),
                 shortint'(x2), shortint'(y2)};
        it.r = '{byte'(c0), byte'(c1), byte'(c2)};
        send_item(it);
    endtask

    // advance items carry random don't-care payloads
    task automatic advance(int n);
        tri_item_t it;
        for (int i = 0; i < n; i++) begin
            it.mode = MODE_ADVANCE;
            for (int k = 0; k < 6; k++) it.v[k] = shortint'($urandom);
            for (int k = 0; k < 3; k++) it.r[k] = byte'($urandom);
            send_item(it);
        end
    endtask

    task automatic wait_drain();
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_height(int h);
        wait_drain();
        cfg_we = 1'b1;
        cfg_data = FH_W'(h);
        @(negedge i_clk);
        cfg_we = 1'b0;
        height = FH_W'(h);
    endtask

    // nothing to scan: after reset and after the last pixel
    task automatic test_idle_advance();
        advance(2);
        load_tri(0, 0, 16, 0, 0, 16, 10, 20, 30);
        advance(4);
        advance(2);
    endtask

    // a scan cut short by a load mid-scan, then a full scan of a small well-wound triangle
    task automatic test_small_triangle();
        load_tri(16, 16, 16, 64, 64, 16, 255, 0, 128);
        advance(5);
        load_tri(0, 0, 48, 0, 0, 48, 255, 255, 255);
        advance(16);
    endtask

    // degenerate and wrongly wound triangles give divide faults
    task automatic test_divide_fault();
        load_tri(0, 0, 32, 32, 64, 64, 50, 60, 70);
        advance(9);
        load_tri(0, 0, 0, 48, 48, 0, 9, 8, 7);
        advance(16);
    endtask

    // coordinate extremes and negative truncation
    task automatic test_extremes();
        load_tri(-32768, -32768, 32767, -32768, -32768, 32767, 255, 255, 0);
        advance(3);
        load_tri(-17, -31, -1, -47, -33, -1, 0, 255, 1);
        advance(12);
    endtask

    task automatic test_frame_height();
        int hs[5] = '{1, 4096, 8191, 0, 1234};
        foreach (hs[i]) begin
            set_height(hs[i]);
            load_tri(-40, 300, 30, -20, 60, 60, $urandom_range(0, 255), 200, 100);
            advance(10);
        end
        set_height(480);
    endtask

    // hold the output so the block fills and stalls its input
    task automatic test_backpressure();
        fork
            begin
                hold_out = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_out = 1'b0;
            end
        join_none
        load_tri(0, 0, 80, 0, 0, 80, 100, 150, 200);
        advance(30);
    endtask

    // mostly small triangles scanned to the end, some huge ones cut short
    task automatic test_random(int budget);
        int sent, bx, by, n, w;
        sent = 0;
        noisy = 1'b0;
        while (sent < budget) begin
            if (sent > 200) noisy = 1'b1;
            if (sent > 500 && sent < 520) begin
                set_height($urandom_range(1, 4096));
            end
            if ($urandom_range(0, 9) == 0) begin
                load_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
                n = $urandom_range(0, 8);
            end else begin
                w = $urandom_range(16, 112);
                bx = int'($urandom_range(0, 65535 - 128)) - 32768;
                by = int'($urandom_range(0, 65535 - 128)) - 32768;
                load_tri(bx + $urandom_range(0, w), by + $urandom_range(0, w),
                    bx + $urandom_range(0, w), by + $urandom_range(0, w),
                    bx + $urandom_range(0, w), by + $urandom_range(0, w),
                    $urandom, $urandom, $urandom);
                n = ((w / 16) + 2) * ((w / 16) + 2);
                n = $urandom_range(0, 3) == 0 ? $urandom_range(0, n) : n + 2;
            end
            advance(n);
            sent += n + 1;
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_idle_advance();
        test_small_triangle();
        test_divide_fault();
        test_extremes();
        test_frame_height();
        test_backpressure();
        test_random(990);
        wait_drain();
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/tefr_pkg.sv
sv/tefr_queue.sv
sv/tefr_front.sv
sv/tefr_back.sv
sv/triangle_edge_function_rasterizer_core.sv
sv/tefr_checker.sv
verif/tb_top.sv
